FILE: src/ohl_pkg.sv
// ---------------------------------------------------------------------------
// ohl_pkg
// Shared types and codes for the ordered handle list: action and status
// codes, the sequencer state type and the result item structure.
// ---------------------------------------------------------------------------
package ohl_pkg;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REPLACE = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_DELETE = 3'd4,
        ACT_GET = 3'd5,
        ACT_CLEAR = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_RANGE = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_SCAN,
        S_GET,
        S_DONE
    } seq_state_t;

    // One finished result item, as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [31:0] handle;
        status_t status;
        logic [4:0] count;
    } res_t;

endpackage

FILE: src/ohl_ram.sv
// ---------------------------------------------------------------------------
// ohl_ram
// Generic single-clock memory with one write port and one read port.
// Read data is registered, so it appears in the cycle after the address.
// ---------------------------------------------------------------------------
module ohl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ohl_seq.sv
// ---------------------------------------------------------------------------
// ohl_seq
// Sequencer for the ordered handle list. Decodes one item, then walks the
// entry memory one entry per cycle to shift, search or read, and holds the
// finished result until the output stage takes it.
// ---------------------------------------------------------------------------
module ohl_seq
    import ohl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int HANDLE_WIDTH = 32,
    parameter int AW = $clog2(CAPACITY)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2:0]              action,
    input  logic [4:0]              position,
    input  logic [31:0]             handle,
    output logic                    busy,
    output logic                    res_valid,
    input  logic                    res_ready,
    output res_t                    res,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_wa,
    output logic [HANDLE_WIDTH-1:0] mem_wd,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_ra,
    input  logic [HANDLE_WIDTH-1:0] mem_rd
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int HW = HANDLE_WIDTH;

    seq_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    action_t op_reg, op_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [HW-1:0] hold_reg, hold_next;
    logic [HW-1:0] res_handle_reg, res_handle_next;
    status_t status_reg, status_next;
    logic found_reg, found_next;

    action_t act;
    logic [HW+31:0] h_ext;
    logic [HW-1:0] h_in;
    logic [HW+31:0] r_ext;
    logic [CMPW-1:0] pos_ext, cnt_ext, ins_ext;
    logic [AW-1:0] cnt_m1;
    logic is_full, ins_range, ins_tail, pos_range, cnt_zero, last, match;

    // Handles are cut to the stored width, or zero extended to it.
    assign h_ext = {{HW{1'b0}}, handle};
    assign h_in = h_ext[HW-1:0];
    assign r_ext = {32'd0, res_handle_reg};

    assign act = action_t'(action);
    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(cnt_reg);
    assign ins_ext = (act == ACT_APPEND) ? cnt_ext : pos_ext;
    assign is_full = (cnt_ext == CMPW'(CAPACITY));
    assign ins_range = (ins_ext > cnt_ext);
    assign ins_tail = (ins_ext == cnt_ext);
    assign pos_range = (pos_ext >= cnt_ext);
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_m1 = AW'(cnt_ext - CMPW'(1));
    assign last = (addr_reg == cnt_m1);
    assign match = !found_reg && ((op_reg == ACT_REMOVE) || (mem_rd == hold_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (act) inside
                        ACT_APPEND, ACT_INSERT:
                        begin
                            if (is_full || ins_range || ins_tail)
                                state_next = S_DONE;
                            else
                                state_next = S_INS;
                        end
                        ACT_REMOVE:
                            state_next = pos_range ? S_DONE : S_SCAN;
                        ACT_DELETE:
                            state_next = cnt_zero ? S_DONE : S_SCAN;
                        ACT_GET:
                            state_next = pos_range ? S_DONE : S_GET;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_INS:
                state_next = (addr_reg == pos_reg) ? S_PUT : S_INS;
            S_PUT:
                state_next = S_DONE;
            S_SCAN:
                state_next = last ? S_DONE : S_SCAN;
            S_GET:
                state_next = S_DONE;
            S_DONE:
                state_next = res_ready ? S_IDLE : S_DONE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        op_next = op_reg;
        pos_next = pos_reg;
        addr_next = addr_reg;
        hold_next = hold_reg;
        res_handle_next = res_handle_reg;
        status_next = status_reg;
        found_next = found_reg;
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = mem_rd;
        mem_re = 1'b0;
        mem_ra = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = act;
                    pos_next = ins_ext[AW-1:0];
                    hold_next = h_in;
                    res_handle_next = '0;
                    status_next = ST_OK;
                    found_next = 1'b0;
                    unique case (act) inside
                        ACT_APPEND, ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (ins_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (ins_tail)
                            begin
                                mem_we = 1'b1;
                                mem_wa = ins_ext[AW-1:0];
                                mem_wd = h_in;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                // Start the upward shift from the last entry.
                                mem_re = 1'b1;
                                mem_ra = cnt_m1;
                                addr_next = cnt_m1;
                            end
                        end
                        ACT_REPLACE:
                        begin
                            if (pos_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_wa = pos_ext[AW-1:0];
                                mem_wd = h_in;
                            end
                        end
                        ACT_REMOVE, ACT_GET:
                        begin
                            if (pos_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_ra = pos_ext[AW-1:0];
                                addr_next = pos_ext[AW-1:0];
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (cnt_zero)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                                mem_ra = '0;
                                addr_next = '0;
                            end
                        end
                        ACT_CLEAR:
                            cnt_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS:
            begin
                mem_we = 1'b1;
                mem_wa = addr_reg + AW'(1);
                mem_wd = mem_rd;
                if (addr_reg != pos_reg)
                begin
                    mem_re = 1'b1;
                    mem_ra = addr_reg - AW'(1);
                    addr_next = addr_reg - AW'(1);
                end
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = hold_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            S_SCAN:
            begin
                // Once the entry is taken, every later entry moves down one slot.
                if (found_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = addr_reg - AW'(1);
                    mem_wd = mem_rd;
                end
                if (match)
                begin
                    found_next = 1'b1;
                    res_handle_next = mem_rd;
                end
                if (last)
                begin
                    if (found_reg || match)
                        cnt_next = cnt_reg - CW'(1);
                    else
                        status_next = ST_NOTFOUND;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = addr_reg + AW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_GET:
                res_handle_next = mem_rd;
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        pos_reg <= pos_next;
        addr_reg <= addr_next;
        hold_reg <= hold_next;
        res_handle_reg <= res_handle_next;
        status_reg <= status_next;
        found_reg <= found_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.handle = r_ext[31:0];
    assign res.status = status_reg;
    assign res.count = cnt_ext[4:0];

endmodule

FILE: src/ordered_handle_list.sv
// ---------------------------------------------------------------------------
// ordered_handle_list
// Ordered list of up to CAPACITY handles with append, insert, replace,
// remove, delete by value, get and clear; one result item per input item.
// ---------------------------------------------------------------------------
// The list lives in one memory with a registered read, and a sequencer
// works on one item at a time, moving at most one entry per cycle through
// that memory. An item is taken only while the sequencer is idle; its
// result then sits in an output register, so the next item can be taken
// while that result waits. Append, replace, clear, unused codes and any
// action refused by its full, range or empty check finish without walking
// the memory. An insert at position p moves each entry from the last down
// to p up one slot, then writes the new handle at p; a remove at p walks
// from p to the end of the list; a get reads a single entry; and a delete
// walks the whole list, whether or not it finds a match. The shift and
// search walk one entry per cycle through the memory's single read and
// single write port, so an insert at the front of a list of 15, or a
// remove at the front or a delete on a full list of 16, is the slowest.
// Reset clears the entry count, the sequencer state and the output valid
// flag, but not the memory: slots at or above the count are never read,
// so the memory needs no clearing pass. A vacated slot is not zeroed for
// the same reason. The entry count reported is the count modulo 32.
module ordered_handle_list
    import ohl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [4:0]  position,
    input  logic [31:0] handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_handle,
    output logic [1:0]  status,
    output logic [4:0]  entry_count
);

    localparam int AW = $clog2(CAPACITY);

    logic busy;
    logic res_valid;
    logic res_ready;
    res_t res;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [HANDLE_WIDTH-1:0] mem_wd;
    logic mem_re;
    logic [AW-1:0] mem_ra;
    logic [HANDLE_WIDTH-1:0] mem_rd;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    // The sequencer only takes an item when it has nothing in flight.
    assign in_stall = busy;

    ohl_seq #(
        .CAPACITY(CAPACITY),
        .HANDLE_WIDTH(HANDLE_WIDTH),
        .AW(AW)
    ) u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .start(in_valid && !in_stall),
        .action(action),
        .position(position),
        .handle(handle),
        .busy(busy),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .mem_we(mem_we),
        .mem_wa(mem_wa),
        .mem_wd(mem_wd),
        .mem_re(mem_re),
        .mem_ra(mem_ra),
        .mem_rd(mem_rd)
    );

    ohl_ram #(
        .WIDTH(HANDLE_WIDTH),
        .DEPTH(CAPACITY),
        .AW(AW)
    ) u_entries (
        .clk(clk),
        .wr_en(mem_we),
        .wr_addr(mem_wa),
        .wr_data(mem_wd),
        .rd_en(mem_re),
        .rd_addr(mem_ra),
        .rd_data(mem_rd)
    );

    // Output register: a new result may load when the register is empty or
    // its current item leaves in this same cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign result_handle = out_res_reg.handle;
    assign status = out_res_reg.status;
    assign entry_count = out_res_reg.count;

`ifndef SYNTHESIS
    // A finished result that the output register cannot take yet must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("sequencer result changed while waiting for the output register");

    // A failed action never reports a handle.
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != ST_OK) |-> res.handle == '0)
        else $error("failed action carries a nonzero handle");

    // Every accepted item occupies the sequencer for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("sequencer free right after taking an item");
`endif

endmodule

FILE: sim/ordered_handle_list_test.sv
// ---------------------------------------------------------------------------
// ordered_handle_list_test
// Self-checking bench for the ordered handle list. Each accepted edit runs
// through a behavioral copy of the list, and the predicted result item is
// queued and compared field by field with what the block returns. Both
// channels idle and stall at random. The stimulus covers the edge cases on
// an empty and a full list, then a long run of random edits.
// ---------------------------------------------------------------------------
module ordered_handle_list_test
    import ohl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAPACITY = 16;
    // The action field is three bits wide, and code 7 has no meaning.
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    // Cycles with no handshake on either channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to watch for stray results once every result has arrived.
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LINES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_APPEND;
    logic [4:0]  position = 5'd0;
    logic [31:0] handle = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result_handle;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    // Behavioral copy of the list, updated when each item is accepted.
    logic [31:0] list_slots [LIST_CAPACITY];
    int          list_len = 0;

    // Results the block still owes, oldest first.
    res_t        pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;

    // While this is set, neither side idles.
    bit          steady = 1'b0;

    ordered_handle_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .position      (position),
        .handle        (handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_handle (result_handle),
        .status        (status),
        .entry_count   (entry_count)
    );

    always #1 clk = ~clk;

    initial
    begin
        foreach (list_slots[i])
        begin
            list_slots[i] = 32'd0;
        end
    end

    // Each side sits out about one cycle in ten, unless a steady stretch is on.
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 10);
    endfunction

    // Pulls the entry at pos out of the list. Later entries close the gap,
    // and the slot left free at the top goes back to zero.
    function automatic logic [31:0] take_slot(input int pos);
        logic [31:0] got;
        got = list_slots[pos];
        for (int i = pos; i + 1 < list_len; i++)
        begin
            list_slots[i] = list_slots[i + 1];
        end
        list_slots[list_len - 1] = 32'd0;
        list_len--;
        return got;
    endfunction

    // Applies one edit to the copy of the list and gives the result item
    // that the block should return for it.
    function automatic res_t apply_list_action(input logic [2:0] act,
                                               input logic [4:0] pos,
                                               input logic [31:0] h);
        res_t r;
        int   p;
        bit   found;
        r = '0;
        p = pos;
        found = 1'b0;
        unique case (act) inside
            ACT_APPEND, ACT_INSERT:
            begin
                // An append is an insert at the end. The full check comes
                // first, so a full list reports full whatever the position.
                if (act == ACT_APPEND)
                begin
                    p = list_len;
                end
                if (list_len >= LIST_CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else if (p > list_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (int i = list_len; i > p; i--)
                    begin
                        list_slots[i] = list_slots[i - 1];
                    end
                    list_slots[p] = h;
                    list_len++;
                end
            end
            ACT_REPLACE:
            begin
                if (p >= list_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    list_slots[p] = h;
                end
            end
            ACT_REMOVE:
            begin
                if (p >= list_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.handle = take_slot(p);
                end
            end
            ACT_DELETE:
            begin
                // Only the first match goes, and a null handle is matched
                // like any other value.
                r.status = ST_NOTFOUND;
                for (int i = 0; i < list_len && !found; i++)
                begin
                    if (list_slots[i] == h)
                    begin
                        r.handle = take_slot(i);
                        r.status = ST_OK;
                        found = 1'b1;
                    end
                end
            end
            ACT_GET:
            begin
                if (p >= list_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.handle = list_slots[p];
                end
            end
            ACT_CLEAR:
            begin
                foreach (list_slots[i])
                begin
                    list_slots[i] = 32'd0;
                end
                list_len = 0;
            end
            default:
            begin
                // The unused code leaves the list alone and reports ok.
            end
        endcase
        r.count = list_len[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_LINES)
        begin
            $display("%0t ns: result %0d %s is %h, should be %h",
                     $realtime, results_seen, field, got, want);
        end
        mismatches++;
    endtask

    // Offers one item, holds it steady until the block takes it, and then
    // queues the result that the item should produce. It starts and ends right
    // after a rising edge, so back-to-back calls keep valid high outside breaks.
    task automatic send_item(input logic [2:0] act, input logic [4:0] pos,
                             input logic [31:0] h);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        handle   <= h;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_results.push_back(apply_list_action(act, pos, h));
    endtask

    // Half the handles come from a few small values or from the list, so that
    // duplicates and delete hits are common; null, all ones and random mix in.
    function automatic logic [31:0] pick_handle();
        case ($urandom_range(0, 9)) inside
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4: return 32'($urandom_range(1, 8));
            5, 6:
            begin
                if (list_len > 0)
                begin
                    return list_slots[$urandom_range(0, list_len - 1)];
                end
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // One random edit. grow_pct sets how often it adds an entry, so that a
    // run of edits drifts the list toward full or toward empty. Most
    // positions are inside the list, the rest anywhere in the field.
    task automatic send_random_edit(input int grow_pct);
        logic [2:0]  act;
        logic [4:0]  pos;
        logic [31:0] h;
        int          roll;
        if ($urandom_range(0, 99) < grow_pct)
        begin
            act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = ACT_CLEAR;
            else if (roll < 4)
                act = ACT_UNUSED;
            else if (roll < 24)
                act = ACT_REPLACE;
            else if (roll < 48)
                act = ACT_REMOVE;
            else if (roll < 72)
                act = ACT_DELETE;
            else
                act = ACT_GET;
        end

        if ($urandom_range(0, 4) == 0)
            pos = 5'($urandom_range(0, 31));
        else if (act == ACT_INSERT)
            pos = 5'($urandom_range(0, list_len));
        else if (list_len > 0)
            pos = 5'($urandom_range(0, list_len - 1));
        else
            pos = 5'd0;

        if (act == ACT_DELETE && list_len > 0 && $urandom_range(0, 9) < 6)
            h = list_slots[$urandom_range(0, list_len - 1)];
        else
            h = pick_handle();

        send_item(act, pos, h);
    endtask

    // Every edit that needs an entry fails on an empty list, and the first
    // insert is allowed only at the front.
    task automatic test_empty_list();
        send_item(ACT_GET, 5'd0, 32'd0);
        send_item(ACT_REMOVE, 5'd31, 32'd0);
        send_item(ACT_REPLACE, 5'd0, 32'h1234_5678);
        send_item(ACT_DELETE, 5'd0, 32'd0);
        send_item(ACT_INSERT, 5'd1, 32'hAAAA_AAAA);
        send_item(ACT_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 5'd0, 32'h5555_5555);
    endtask

    // Fills the list with extreme handles, then pushes against the full
    // limit and the top end of the positions.
    task automatic test_full_list();
        send_item(ACT_APPEND, 5'd31, 32'd0);
        send_item(ACT_INSERT, 5'd0, 32'hFFFF_FFFF);
        for (int i = 3; i <= LIST_CAPACITY; i++)
        begin
            send_item(ACT_APPEND, 5'd0, (i % 2) ? 32'h8000_0001 : 32'h7FFF_FFFE);
        end
        send_item(ACT_APPEND, 5'd0, 32'hDEAD_BEEF);
        send_item(ACT_INSERT, 5'd31, 32'hDEAD_BEEF);
        send_item(ACT_GET, 5'd15, 32'd0);
        send_item(ACT_GET, 5'd16, 32'd0);
        // A null handle sits in the list, so a delete of null finds it.
        send_item(ACT_DELETE, 5'd0, 32'd0);
        send_item(ACT_CLEAR, 5'd0, 32'd0);
    endtask

    // Long random run with idling on both sides. The drift toward growth or
    // shrinkage changes every few dozen items, so the list keeps sweeping
    // between empty and full.
    task automatic test_random_edits(input int n_items);
        int grow_pct;
        grow_pct = 45;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: grow_pct = 20;
                    1: grow_pct = 45;
                    default: grow_pct = 70;
                endcase
            end
            send_random_edit(grow_pct);
        end
    endtask

    // Same mix with neither side idling, so items arrive while the previous
    // result still waits in the output register.
    task automatic test_streaming_edits(input int n_items);
        steady = 1'b1;
        test_random_edits(n_items);
        steady = 1'b0;
    endtask

    // Result checker. Handshake signals and fields are read before this
    // edge's updates land, and the stall for the next cycle is drawn here.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("with none outstanding, handle", result_handle, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_handle !== want.handle)
                    report_mismatch("handle", result_handle, want.handle);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (entry_count !== want.count)
                    report_mismatch("count", 32'(entry_count), 32'(want.count));
            end
            results_seen++;
        end
        out_stall <= take_break();
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Test sequence: reset once, run each test in turn, then wait for the
    // last results and give stray ones a chance to show up.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_full_list();
        test_random_edits(700);
        test_streaming_edits(300);
        test_random_edits(400);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
